// File: rtl/great_circle_initial_bearing_defines.svh
// ----------------------------------------------------------------------------
// great_circle_initial_bearing_defines: assertion macros.
// Short forms for clocked assertions with a synchronous reset that disables them.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_INITIAL_BEARING_DEFINES_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCIB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCIB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gcib_pkg.sv
// ----------------------------------------------------------------------------
// gcib_pkg: shared constants for the great-circle bearing pipeline.
// Binary-angle scaling, angle conversion constants, CORDIC gain and arctangent table.
// ----------------------------------------------------------------------------
package gcib_pkg;

  // Default number of CORDIC iterations in each rotation chain.
  localparam int CORDIC_STAGES_DEF = 24;

  // The conversion to a binary angle takes four register stages.
  localparam int ANGLE_STAGES = 4;

  // One full turn and two full turns in units of 1e-7 degree.
  localparam logic signed [34:0] TURN_E7  = 35'sd3600000000;
  localparam logic signed [34:0] TURN2_E7 = 35'sd7200000000;

  // The same full turn and its half as plain unsigned words.
  localparam logic [31:0] TURN_E7_U      = 32'd3600000000;
  localparam logic [31:0] HALF_TURN_E7_U = 32'd1800000000;

  // floor(2^64 / full turn) is 2^32 plus this fractional part.
  localparam logic [29:0] ANG_RECIP_LO = 30'd829128280;

  // Start value of the rotation chain: reciprocal of the CORDIC gain in Q30.
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD3B6A;

  // Half a turn as a binary angle, also used as the rounding half of 2^32.
  localparam logic [31:0] HALF_TURN_BA = 32'h80000000;

  // Millidegrees in a full and in a half turn.
  localparam logic [18:0] MDEG_TURN = 19'd360000;
  localparam logic [18:0] MDEG_HALF = 19'd180000;

  // atan(2^-i) as a binary angle, full turn = 2^32.
  function automatic logic [31:0] atan_tab(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/great_circle_initial_bearing.sv
// ----------------------------------------------------------------------------
// great_circle_initial_bearing: initial forward azimuth between two positions.
// One item enters per cycle while the output is not stalled.
// Most of the depth comes from the four-stage angle conversions and the two CORDIC chains.
// Synchronous reset clears the valid bits only; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "great_circle_initial_bearing_defines.svh"

module great_circle_initial_bearing #(
  parameter int CORDIC_STAGES = gcib_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] from_lat,
  input  logic signed [31:0] from_lon,
  input  logic signed [30:0] to_lat,
  input  logic signed [31:0] to_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [18:0] bearing
);

  // Stage map. Stage 0 reduces the three angles modulo a full turn. Stages
  // 1 to CONV_N convert them to binary angles by reciprocal multiplication.
  // The sine/cosine chains follow, then a sign fix-up, three product stages,
  // the atan2 set-up, the vectoring chain and three output stages.
  localparam int CONV_N = gcib_pkg::ANGLE_STAGES;
  localparam int N      = CORDIC_STAGES;
  localparam int S_NEG  = CONV_N + N + 1;
  localparam int S_P1   = S_NEG + 1;
  localparam int S_P2   = S_P1 + 1;
  localparam int S_P3   = S_P2 + 1;
  localparam int S_A0   = S_P3 + 1;
  localparam int S_O1   = S_A0 + N + 1;
  localparam int S_O2   = S_O1 + 1;
  localparam int S_O3   = S_O2 + 1;
  localparam int DEPTH  = S_O3 + 1;

  // The whole pipeline moves as one. It advances whenever the output
  // register is empty or its item is being taken, so a stall freezes every
  // stage in place and nothing is lost or repeated.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Valid bits travel alongside the data. The zero flag marks items whose
  // bearing is forced to zero: coincident points, or a vector of length zero.
  logic [DEPTH-1:0] vld;
  logic [DEPTH-1:0] zf;
  logic [DEPTH-1:0] zf_next;
  logic             coin;
  logic             xy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    zf_next        = {zf[DEPTH-2:0], coin};
    zf_next[S_A0]  = zf[S_A0-1] | xy0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zf <= zf_next;
    end
  end

  assign out_valid = vld[DEPTH-1];

  // --------------------------------------------------------------------------
  // Stage 0: modulo reduction. Latitudes need at most one turn added. The
  // longitude difference spans more than a turn either way, so all candidate
  // corrections are formed side by side and the right one is picked.
  // Lane 0 is the start latitude, lane 1 the target latitude and lane 2 the
  // longitude difference.
  // --------------------------------------------------------------------------
  logic signed [34:0] dlon;
  logic signed [34:0] dl_p2;
  logic signed [34:0] dl_p1;
  logic signed [34:0] dl_m1;
  logic [31:0]        r_lane [3];

  assign dlon  = 35'(to_lon) - 35'(from_lon);
  assign dl_p2 = dlon + gcib_pkg::TURN2_E7;
  assign dl_p1 = dlon + gcib_pkg::TURN_E7;
  assign dl_m1 = dlon - gcib_pkg::TURN_E7;

  always_comb begin
    r_lane[0] = from_lat[30] ? 32'(33'(from_lat) + 33'(gcib_pkg::TURN_E7))
                             : 32'(33'(from_lat));
    r_lane[1] = to_lat[30] ? 32'(33'(to_lat) + 33'(gcib_pkg::TURN_E7))
                           : 32'(33'(to_lat));
    if (dl_p1[34]) begin
      r_lane[2] = dl_p2[31:0];
    end else if (dlon[34]) begin
      r_lane[2] = dl_p1[31:0];
    end else if (!dl_m1[34]) begin
      r_lane[2] = dl_m1[31:0];
    end else begin
      r_lane[2] = dlon[31:0];
    end
  end

  // Coincident points: equal latitudes and a longitude difference that is a
  // whole number of turns, which maps to a binary angle of zero.
  assign coin = (from_lat == to_lat) &&
                ((dlon == '0) || (dlon == gcib_pkg::TURN_E7) ||
                 (dlon == -gcib_pkg::TURN_E7));

  // --------------------------------------------------------------------------
  // Stages 1 to CONV_N: the binary angle floor((r * 2^32 + T/2) / T), with T a
  // full turn. The reciprocal floor(2^64 / T) is 2^32 plus a fractional part.
  // Stage 1 multiplies r by that part; stage 2 adds r and the rounding half,
  // which gives an estimate never above the exact quotient and at most one
  // below it. Stage 3 multiplies the estimate back by T, and stage 4 adds one
  // where the remainder still reaches a full turn.
  // --------------------------------------------------------------------------
  logic [31:0] ar0_q [3];
  logic [31:0] ar1_q [3];
  logic [61:0] ap1_q [3];
  logic [31:0] est   [3];
  logic [31:0] ar2_q [3];
  logic [31:0] aq2_q [3];
  logic [31:0] ar3_q [3];
  logic [31:0] aq3_q [3];
  logic [63:0] am3_q [3];
  logic [33:0] arem  [3];
  logic [31:0] ang_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      est[l]  = ar1_q[l] +
                32'((64'(ap1_q[l]) + 64'(gcib_pkg::HALF_TURN_BA)) >> 32);
      arem[l] = 34'({ar3_q[l], gcib_pkg::HALF_TURN_E7_U} - am3_q[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        ar0_q[l] <= r_lane[l];
        ar1_q[l] <= ar0_q[l];
        ap1_q[l] <= 62'(ar0_q[l]) * 62'(gcib_pkg::ANG_RECIP_LO);
        ar2_q[l] <= ar1_q[l];
        aq2_q[l] <= est[l];
        ar3_q[l] <= ar2_q[l];
        aq3_q[l] <= aq2_q[l];
        am3_q[l] <= 64'(aq2_q[l]) * 64'(gcib_pkg::TURN_E7_U);
        ang_q[l] <= aq3_q[l] + 32'(arem[l] >= 34'(gcib_pkg::TURN_E7_U));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sine and cosine by CORDIC rotation, one iteration per stage, three lanes.
  // An angle in the left half-plane is turned by half a turn first and the
  // results are negated afterwards, which keeps the residual within range.
  // --------------------------------------------------------------------------
  logic signed [33:0] sx   [N][3];
  logic signed [33:0] sy   [N][3];
  logic signed [33:0] sz   [N][3];
  logic               sneg [N][3];

  for (genvar i = 0; i < N; i++) begin : g_sc
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [33:0] x_in;
      logic signed [33:0] y_in;
      logic signed [33:0] z_in;
      logic               neg_in;
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] at;

      if (i == 0) begin : g_first
        logic [31:0] ang;
        logic [31:0] ang_f;

        assign ang    = ang_q[l];
        assign neg_in = ang[31] ^ ang[30];
        assign ang_f  = {ang[31] ^ neg_in, ang[30:0]};
        assign x_in   = 34'(gcib_pkg::CORDIC_GAIN);
        assign y_in   = '0;
        assign z_in   = {{2{ang_f[31]}}, ang_f};
      end else begin : g_rest
        assign neg_in = sneg[i-1][l];
        assign x_in   = sx[i-1][l];
        assign y_in   = sy[i-1][l];
        assign z_in   = sz[i-1][l];
      end

      assign dx = y_in >>> i;
      assign dy = x_in >>> i;
      assign at = 34'(gcib_pkg::atan_tab(5'(i)));

      always_ff @(posedge clk) begin
        if (adv) begin
          if (!z_in[33]) begin
            sx[i][l] <= x_in - dx;
            sy[i][l] <= y_in + dy;
            sz[i][l] <= z_in - at;
          end else begin
            sx[i][l] <= x_in + dx;
            sy[i][l] <= y_in - dy;
            sz[i][l] <= z_in + at;
          end
          sneg[i][l] <= neg_in;
        end
      end
    end
  end

  // Sign fix-up. The results lie within about one in Q30, so 32 bits hold them.
  logic signed [31:0] sn_q [3];
  logic signed [31:0] cn_q [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        sn_q[l] <= sneg[N-1][l] ? 32'(-sy[N-1][l]) : 32'(sy[N-1][l]);
        cn_q[l] <= sneg[N-1][l] ? 32'(-sx[N-1][l]) : 32'(sx[N-1][l]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Products in Q30 with floor rounding. The first stage forms sin(dlon)cos(lat2),
  // cos(lat1)sin(lat2) and sin(lat1)cos(lat2); the second multiplies the last
  // of these by cos(dlon); the third forms the difference that is x.
  // --------------------------------------------------------------------------
  logic signed [63:0] m_y;
  logic signed [63:0] m_a;
  logic signed [63:0] m_b;
  logic signed [63:0] m_c;
  logic signed [31:0] py1_q;
  logic signed [31:0] pa1_q;
  logic signed [31:0] pb1_q;
  logic signed [31:0] cd1_q;
  logic signed [31:0] py2_q;
  logic signed [31:0] pa2_q;
  logic signed [31:0] pc2_q;
  logic signed [32:0] xr_q;
  logic signed [32:0] yr_q;

  assign m_y = sn_q[2] * cn_q[1];
  assign m_a = cn_q[0] * sn_q[1];
  assign m_b = sn_q[0] * cn_q[1];
  assign m_c = pb1_q * cd1_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      py1_q <= m_y[61:30];
      pa1_q <= m_a[61:30];
      pb1_q <= m_b[61:30];
      cd1_q <= cn_q[2];
      py2_q <= py1_q;
      pa2_q <= pa1_q;
      pc2_q <= m_c[61:30];
      xr_q  <= 33'(pa2_q) - 33'(pc2_q);
      yr_q  <= 33'(py2_q);
    end
  end

  // --------------------------------------------------------------------------
  // atan2 set-up: a vector in the left half-plane is turned by half a turn so
  // that the vectoring chain starts with a non-negative x.
  // --------------------------------------------------------------------------
  logic signed [35:0] a0x_q;
  logic signed [35:0] a0y_q;
  logic [31:0]        a0z_q;

  assign xy0 = (xr_q == '0) && (yr_q == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      a0x_q <= xr_q[32] ? -36'(xr_q) : 36'(xr_q);
      a0y_q <= xr_q[32] ? -36'(yr_q) : 36'(yr_q);
      a0z_q <= xr_q[32] ? gcib_pkg::HALF_TURN_BA : '0;
    end
  end

  // Vectoring chain. The angle accumulates modulo a full turn.
  logic signed [35:0] ax [N];
  logic signed [35:0] ay [N];
  logic [31:0]        az [N];

  for (genvar j = 0; j < N; j++) begin : g_at
    logic signed [35:0] x_in;
    logic signed [35:0] y_in;
    logic [31:0]        z_in;
    logic signed [35:0] dx;
    logic signed [35:0] dy;
    logic               ypos;

    if (j == 0) begin : g_first
      assign x_in = a0x_q;
      assign y_in = a0y_q;
      assign z_in = a0z_q;
    end else begin : g_rest
      assign x_in = ax[j-1];
      assign y_in = ay[j-1];
      assign z_in = az[j-1];
    end

    assign dx   = y_in >>> j;
    assign dy   = x_in >>> j;
    assign ypos = !y_in[35] && (y_in != '0);

    always_ff @(posedge clk) begin
      if (adv) begin
        if (ypos) begin
          ax[j] <= x_in + dx;
          ay[j] <= y_in - dy;
          az[j] <= z_in + gcib_pkg::atan_tab(5'(j));
        end else begin
          ax[j] <= x_in - dx;
          ay[j] <= y_in + dy;
          az[j] <= z_in - gcib_pkg::atan_tab(5'(j));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output: scale the binary angle to millidegrees with round half up, wrap
  // into (-180, 180] degrees, and force zero for flagged items. The last
  // register is the output register.
  // --------------------------------------------------------------------------
  logic [50:0]        op_q;
  logic [50:0]        op_rnd;
  logic [18:0]        mdeg_q;
  logic signed [18:0] bearing_q;

  assign op_rnd = op_q + 51'(gcib_pkg::HALF_TURN_BA);

  always_ff @(posedge clk) begin
    if (adv) begin
      op_q   <= 51'(az[N-1]) * 51'(gcib_pkg::MDEG_TURN);
      mdeg_q <= op_rnd[50:32];
      if (zf[S_O2]) begin
        bearing_q <= '0;
      end else if (mdeg_q > gcib_pkg::MDEG_HALF) begin
        bearing_q <= mdeg_q - gcib_pkg::MDEG_TURN;
      end else begin
        bearing_q <= mdeg_q;
      end
    end
  end

  assign bearing = bearing_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `GCIB_ASSERT_NOW(a_bearing_range, clk, rst, out_valid,
                   (bearing <= 19'sd180000) && (bearing >= -19'sd179999),
                   "bearing outside (-180, 180] degrees")
  `GCIB_ASSERT_NOW(a_zero_forced, clk, rst, vld[DEPTH-1] && zf[DEPTH-1], bearing == '0,
                   "flagged item did not give a zero bearing")
  `GCIB_ASSERT_NEXT(a_stall_freeze, clk, rst, !adv, $stable(vld),
                    "valid bits moved during a stall")

endmodule
